>>> rtl/sars_pkg.sv
// Types and constants shared by the SPI addressed register slave.
package sars_pkg;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
	} cmd_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       miso_drive;
		logic       frame_done;
		logic       next_addr_valid;
		logic [2:0] next_addr;
	} res_t;

	localparam logic [1:0] FUNC_START   = 2'd0;
	localparam logic [1:0] FUNC_BYTE    = 2'd1;
	localparam logic [1:0] FUNC_SERVICE = 2'd2;

	localparam logic [1:0] PH_OPCODE = 2'd0;
	localparam logic [1:0] PH_INDEX  = 2'd1;
	localparam logic [1:0] PH_XFER   = 2'd2;

	localparam logic [7:0] OPC_MASK  = 8'hC1;
	localparam logic [7:0] ADDR_MASK = 8'h3E;

	localparam logic [7:0] SW_IDX_A = 8'h05;
	localparam logic [7:0] SW_IDX_B = 8'h0A;
	localparam logic [7:0] SW_IDX_C = 8'h0B;
	localparam logic [7:0] SW_IDX_D = 8'h0F;

	// Entries tracked for service events: register 0 up to 1 + 15; a service event tests 1 up to 1 + 15.
	localparam int NZ_N = 17;
	localparam int NZ_W = $clog2(NZ_N);

	localparam logic [2:0] REG_BASE_CODE  = 3'd0;
	localparam logic [2:0] REG_CFG_SELECT = 3'd1;
	localparam logic [2:0] REG_USER_COUNT = 3'd2;
	localparam logic [2:0] REG_DEV_ADDR   = 3'd3;
	localparam logic [2:0] REG_EN_CODE    = 3'd4;
	localparam logic [2:0] REG_DIS_CODE   = 3'd5;

endpackage

>>> rtl/sars_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sars_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/spi_addressed_register_slave.sv
// Top level of the SPI addressed register slave: frame decoder, register bank, APB registers.
//
//   channel | direction | handshake               | word
//   cmd     | in        | cmd_valid / cmd_stall   | cmd_word (func, rx_byte)
//   res     | out       | res_valid / res_stall   | res_word (tx, miso, done, chain address)
//   apb     | in        | psel / penable / pready | paddr, pwdata, prdata
//
// One word is accepted per cycle while cmd_stall is low; the output stage presents its result.
// The accept edge registers the word; on advance, the frame state updates and the bank is read.
// The bank read data register forms the result together with the output stage.
// Reset clears all control state and the bank valid bits and resets the configuration at once.
// A stalled result holds the output stage; the input stage takes one more word behind it.
module spi_addressed_register_slave #(
	parameter int CTRL_REGS     = 16,
	parameter int MAX_USER_REGS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  sars_pkg::cmd_t   cmd_word,
	output logic             res_valid,
	input  logic             res_stall,
	output sars_pkg::res_t   res_word,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int BANK_SIZE = CTRL_REGS + MAX_USER_REGS;
	localparam int AW = $clog2(BANK_SIZE);
	localparam int PW = $clog2(BANK_SIZE + 1);
	localparam int CW = (PW > 8) ? PW : 8;

	logic [7:0] base_q;
	logic [3:0] csel_q;
	logic [6:0] ucnt_q;
	logic [2:0] dev_q;
	logic [7:0] en_q;
	logic [7:0] dis_q;

	logic [2:0] cfg_idx;
	logic       cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			csel_q <= '0;
			ucnt_q <= '0;
			dev_q  <= '0;
			en_q   <= 8'd1;
			dis_q  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				sars_pkg::REG_BASE_CODE:  base_q <= pwdata[7:0];
				sars_pkg::REG_CFG_SELECT: csel_q <= pwdata[3:0];
				sars_pkg::REG_USER_COUNT: ucnt_q <= pwdata[6:0];
				sars_pkg::REG_DEV_ADDR:   dev_q  <= pwdata[2:0];
				sars_pkg::REG_EN_CODE:    en_q   <= pwdata[7:0];
				sars_pkg::REG_DIS_CODE:   dis_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			sars_pkg::REG_BASE_CODE:  prdata = {24'd0, base_q};
			sars_pkg::REG_CFG_SELECT: prdata = {28'd0, csel_q};
			sars_pkg::REG_USER_COUNT: prdata = {25'd0, ucnt_q};
			sars_pkg::REG_DEV_ADDR:   prdata = {29'd0, dev_q};
			sars_pkg::REG_EN_CODE:    prdata = {24'd0, en_q};
			sars_pkg::REG_DIS_CODE:   prdata = {24'd0, dis_q};
			default:                  prdata = '0;
		endcase
	end

	// Pipeline control.
	logic           cmd_valid_s1;
	sars_pkg::cmd_t cmd_s1;
	logic           adv;
	logic           fire_s1;

	assign adv       = !res_valid || !res_stall;
	assign cmd_stall = cmd_valid_s1 && !adv;
	assign fire_s1   = cmd_valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd_word;
		end
	end

	// Frame state.
	logic [1:0]              phase_q, phase_d;
	logic [1:0]              bcnt_q, bcnt_d;
	logic [7:0]              opc_q, opc_d;
	logic [PW-1:0]           ptr_q, ptr_d;
	logic                    match_q, match_d;
	logic                    done_q, done_d;
	logic                    drive_q, drive_d;
	logic [2:0]              chain_q, chain_d;
	logic [sars_pkg::NZ_N-1:0] nz_q, nz_d;
	logic [2:0]              sh0_q, sh0_d;
	logic [BANK_SIZE-1:0]    vld_q;

	logic [6:0]          ucnt_cl;
	logic [PW-1:0]       count;
	logic [CW-1:0]       cnt_m1;
	logic [CW-1:0]       data_cw;
	logic [CW-1:0]       xptr_cw;
	logic [PW-1:0]       xptr;
	logic [sars_pkg::NZ_W-1:0] sel;
	logic [7:0]          data;
	logic                skip;
	logic                xfer;
	logic                rd_hit;
	logic                wr_hit;
	logic                is_sw;
	logic                na;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [7:0]          ram_wdata;
	logic                ram_re;

	assign ucnt_cl = (ucnt_q > 7'(MAX_USER_REGS)) ? 7'(MAX_USER_REGS) : ucnt_q;
	assign count   = PW'(CTRL_REGS) + PW'(ucnt_cl);
	assign cnt_m1  = CW'(count) - CW'(1);
	assign data    = cmd_s1.rx_byte;
	assign data_cw = CW'(data);
	assign sel     = sars_pkg::NZ_W'(csel_q) + sars_pkg::NZ_W'(1);

	always_comb begin
		phase_d   = phase_q;
		bcnt_d    = bcnt_q;
		opc_d     = opc_q;
		ptr_d     = ptr_q;
		match_d   = match_q;
		done_d    = done_q;
		drive_d   = drive_q;
		chain_d   = chain_q;
		nz_d      = nz_q;
		sh0_d     = sh0_q;
		skip      = 1'b0;
		xfer      = 1'b0;
		rd_hit    = 1'b0;
		wr_hit    = 1'b0;
		is_sw     = 1'b0;
		na        = 1'b0;
		xptr      = ptr_q;
		xptr_cw   = CW'(ptr_q);
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		case (cmd_s1.func)
			sars_pkg::FUNC_START: begin
				drive_d = 1'b0;
				phase_d = sars_pkg::PH_OPCODE;
				bcnt_d  = '0;
			end
			sars_pkg::FUNC_BYTE: begin
				if (bcnt_q != 2'd3) begin
					bcnt_d = bcnt_q + 2'd1;
				end
				if (bcnt_d == 2'd1) begin
					opc_d = data & sars_pkg::OPC_MASK;
					if (!match_q || ((data & sars_pkg::ADDR_MASK) >> 1) == {5'd0, dev_q}) begin
						phase_d = sars_pkg::PH_INDEX;
						drive_d = 1'b1;
					end else begin
						drive_d = 1'b0;
					end
				end else if (bcnt_d == 2'd2 && phase_q == sars_pkg::PH_INDEX) begin
					ptr_d   = (data_cw < cnt_m1) ? data_cw[PW-1:0] : cnt_m1[PW-1:0];
					phase_d = sars_pkg::PH_XFER;
					skip    = (opc_d == base_q);
				end
				xptr    = ptr_d;
				xptr_cw = CW'(ptr_d);
				xfer    = !skip && phase_d == sars_pkg::PH_XFER && ptr_d < count;
				rd_hit  = ({1'b0, opc_d} == ({1'b0, base_q} + 9'd1));
				wr_hit  = (opc_d == base_q);
				is_sw   = xptr_cw == CW'(sars_pkg::SW_IDX_A) || xptr_cw == CW'(sars_pkg::SW_IDX_B) ||
					xptr_cw == CW'(sars_pkg::SW_IDX_C) || xptr_cw == CW'(sars_pkg::SW_IDX_D);
				if (xfer) begin
					if (rd_hit) begin
						ram_re = 1'b1;
					end else if (wr_hit) begin
						if (is_sw) begin
							if (data == en_q) begin
								match_d = 1'b1;
							end else if (data == dis_q) begin
								match_d = 1'b0;
							end
						end else begin
							ram_we    = 1'b1;
							ram_waddr = xptr[AW-1:0];
							ram_wdata = data;
							if (xptr_cw < CW'(sars_pkg::NZ_N)) begin
								nz_d[xptr[sars_pkg::NZ_W-1:0]] = (data != 8'd0);
							end
							if (xptr_cw == '0) begin
								sh0_d = data[2:0];
							end
						end
					end
					ptr_d = xptr + PW'(1);
					if (ptr_d == count) begin
						done_d = 1'b1;
					end
				end
			end
			sars_pkg::FUNC_SERVICE: begin
				if (done_q) begin
					ptr_d  = '0;
					done_d = 1'b0;
					if (nz_q[sel]) begin
						nz_d[sel] = 1'b0;
						ram_we    = 1'b1;
						ram_waddr = AW'(sel);
						ram_wdata = '0;
						chain_d   = sh0_q;
						na        = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sars_pkg::PH_OPCODE;
			bcnt_q  <= '0;
			opc_q   <= '0;
			ptr_q   <= '0;
			match_q <= 1'b0;
			done_q  <= 1'b0;
			drive_q <= 1'b0;
			chain_q <= '0;
			nz_q    <= '0;
			sh0_q   <= '0;
			vld_q   <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			bcnt_q  <= bcnt_d;
			opc_q   <= opc_d;
			ptr_q   <= ptr_d;
			match_q <= match_d;
			done_q  <= done_d;
			drive_q <= drive_d;
			chain_q <= chain_d;
			nz_q    <= nz_d;
			sh0_q   <= sh0_d;
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
		end
	end

	// Register bank; entries not yet written read as zero through the valid bits.
	logic [7:0] ram_rdata;

	sars_ram #(
		.WIDTH(8),
		.DEPTH(BANK_SIZE)
	) u_bank (
		.clk   (clk),
		.we    (fire_s1 && ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (fire_s1 && ram_re),
		.raddr (xptr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Output stage.
	logic       txv_s2;
	logic       rvld_s2;
	logic       miso_s2;
	logic       done_s2;
	logic       na_s2;
	logic [2:0] chain_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= cmd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			txv_s2   <= ram_re;
			rvld_s2  <= vld_q[xptr[AW-1:0]];
			miso_s2  <= drive_d;
			done_s2  <= done_d;
			na_s2    <= na;
			chain_s2 <= chain_d;
		end
	end

	always_comb begin
		res_word.tx_valid        = txv_s2;
		res_word.tx_byte         = (txv_s2 && rvld_s2) ? ram_rdata : 8'd0;
		res_word.miso_drive      = miso_s2;
		res_word.frame_done      = done_s2;
		res_word.next_addr_valid = na_s2;
		res_word.next_addr       = chain_s2;
	end

	a_na_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.next_addr_valid |-> !res_word.frame_done)
		else $error("chain address update with completion flag still set");

	a_tx_needs_drive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.tx_valid |-> res_word.miso_drive)
		else $error("transmit byte loaded while MISO is released");

	a_bank_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |-> !(ram_we && ram_re))
		else $error("bank read and write by the same word");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the SPI addressed register slave: directed and random frames.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CTRL_REGS = 16;
	localparam int MAX_USER_REGS = 64;
	localparam int BANK_DEPTH = CTRL_REGS + MAX_USER_REGS;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int PHASES = 7;
	localparam int PHASE_WORDS = 220;
	localparam int HOLD_AT = 360;
	localparam int HOLD_LEN = 150;
	localparam int CALM_FROM = 1500;
	localparam int CALM_TO = 2300;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic has_lit;
		sars_pkg::cmd_t c;
		sars_pkg::res_t lit;
	} stim_t;

	localparam logic [2:0] CFG_ORDER [6] = '{sars_pkg::REG_BASE_CODE, sars_pkg::REG_CFG_SELECT,
		sars_pkg::REG_USER_COUNT, sars_pkg::REG_DEV_ADDR, sars_pkg::REG_EN_CODE,
		sars_pkg::REG_DIS_CODE};

	localparam stim_t DIR_TAB [26] = '{
		{1'b1, sars_pkg::FUNC_SERVICE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_BYTE,    8'hFF, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_START,   8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_BYTE,    8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_BYTE,    8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 3'd0},
		{1'b0, sars_pkg::FUNC_BYTE,    8'h05, 15'd0},
		{1'b0, sars_pkg::FUNC_BYTE,    8'hFF, 15'd0},
		{1'b1, sars_pkg::FUNC_START,   8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_BYTE,    8'h01, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_BYTE,    8'h00, 1'b1, 8'h05, 1'b1, 1'b0, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_BYTE,    8'h00, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_START,   8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_BYTE,    8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_BYTE,    8'hFF, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_BYTE,    8'h01, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_BYTE,    8'h22, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 3'd0},
		{1'b1, sars_pkg::FUNC_SERVICE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 3'd5},
		{1'b1, sars_pkg::FUNC_START,   8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3'd5},
		{1'b1, sars_pkg::FUNC_BYTE,    8'h3E, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3'd5},
		{1'b0, sars_pkg::FUNC_BYTE,    8'h01, 15'd0},
		{1'b0, sars_pkg::FUNC_BYTE,    8'h01, 15'd0},
		{1'b1, FUNC_NONE,              8'hAA, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3'd5},
		{1'b0, sars_pkg::FUNC_START,   8'h00, 15'd0},
		{1'b0, sars_pkg::FUNC_BYTE,    8'h00, 15'd0},
		{1'b0, sars_pkg::FUNC_BYTE,    8'h0A, 15'd0},
		{1'b1, sars_pkg::FUNC_BYTE,    8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 3'd5}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	sars_pkg::cmd_t cmd_word = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	sars_pkg::res_t res_word;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [7:0] c_base = 8'h00;
	logic [3:0] c_sel = 4'd0;
	logic [6:0] c_users = 7'd0;
	logic [2:0] c_dev = 3'd0;
	logic [7:0] c_en = 8'h01;
	logic [7:0] c_dis = 8'h00;

	logic [1:0] m_phase = sars_pkg::PH_OPCODE;
	logic [1:0] m_cnt = 2'd0;
	logic [7:0] m_opc = 8'h00;
	logic [6:0] m_ptr = 7'd0;
	logic m_match = 1'b0;
	logic m_done = 1'b0;
	logic m_drive = 1'b0;
	logic [2:0] m_chain = 3'd0;
	logic [7:0] m_bank [BANK_DEPTH];

	stim_t word_backlog [$];
	sars_pkg::res_t resp_due [$];
	stim_t cur = '0;
	logic offering = 1'b0;
	int words_queued = 0;
	int seen = 0;
	int hold_left = 0;
	int errors = 0;
	int cycles = 0;
	logic calm;

	assign calm = (cycles >= CALM_FROM) && (cycles < CALM_TO);

	spi_addressed_register_slave #(
		.CTRL_REGS(CTRL_REGS),
		.MAX_USER_REGS(MAX_USER_REGS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word(cmd_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("** spi_addressed_register_slave: FAILED **");
			$finish;
		end
	end

	function automatic int reg_total();
		return CTRL_REGS + ((c_users > MAX_USER_REGS) ? MAX_USER_REGS : int'(c_users));
	endfunction

	// Advances the slave's frame state by one word and returns the response it must give.
	function automatic sars_pkg::res_t slave_response(input sars_pkg::cmd_t c);
		sars_pkg::res_t r;
		int total;
		int sel;
		logic skip;
		logic [4:0] req;
		r = '0;
		skip = 1'b0;
		total = reg_total();
		case (c.func)
			sars_pkg::FUNC_START: begin
				m_drive = 1'b0;
				m_phase = sars_pkg::PH_OPCODE;
				m_cnt = 2'd0;
			end
			sars_pkg::FUNC_BYTE: begin
				if (m_cnt < 2'd3)
					m_cnt++;
				if (m_cnt == 2'd1) begin
					req = 5'((c.rx_byte & sars_pkg::ADDR_MASK) >> 1);
					m_opc = c.rx_byte & sars_pkg::OPC_MASK;
					if (!m_match || req == {2'b00, c_dev}) begin
						m_phase = sars_pkg::PH_INDEX;
						m_drive = 1'b1;
					end else begin
						m_drive = 1'b0;
					end
				end else if (m_cnt == 2'd2 && m_phase == sars_pkg::PH_INDEX) begin
					m_ptr = (int'(c.rx_byte) < total - 1) ? 7'(c.rx_byte) : 7'(total - 1);
					m_phase = sars_pkg::PH_XFER;
					if (m_opc == c_base)
						skip = 1'b1;
				end
				if (!skip && m_phase == sars_pkg::PH_XFER && int'(m_ptr) < total) begin
					if ({1'b0, m_opc} == {1'b0, c_base} + 9'd1) begin
						r.tx_valid = 1'b1;
						r.tx_byte = m_bank[m_ptr];
					end else if (m_opc == c_base) begin
						if ({1'b0, m_ptr} == sars_pkg::SW_IDX_A
								|| {1'b0, m_ptr} == sars_pkg::SW_IDX_B
								|| {1'b0, m_ptr} == sars_pkg::SW_IDX_C
								|| {1'b0, m_ptr} == sars_pkg::SW_IDX_D) begin
							if (c.rx_byte == c_en)
								m_match = 1'b1;
							else if (c.rx_byte == c_dis)
								m_match = 1'b0;
						end else begin
							m_bank[m_ptr] = c.rx_byte;
						end
					end
					m_ptr++;
					if (int'(m_ptr) == total)
						m_done = 1'b1;
				end
			end
			sars_pkg::FUNC_SERVICE: begin
				if (m_done) begin
					sel = int'(c_sel) + 1;
					m_ptr = 7'd0;
					m_done = 1'b0;
					if (m_bank[sel] != 8'h00) begin
						m_bank[sel] = 8'h00;
						m_chain = m_bank[0][2:0];
						r.next_addr_valid = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		r.miso_drive = m_drive;
		r.frame_done = m_done;
		r.next_addr = m_chain;
		return r;
	endfunction

	task automatic compare_response(input sars_pkg::res_t got, input sars_pkg::res_t want);
		if (got.tx_valid !== want.tx_valid) begin
			$error("tx_valid: expected %0h, got %0h", want.tx_valid, got.tx_valid);
			errors++;
		end
		if (got.tx_byte !== want.tx_byte) begin
			$error("tx_byte: expected %0h, got %0h", want.tx_byte, got.tx_byte);
			errors++;
		end
		if (got.miso_drive !== want.miso_drive) begin
			$error("miso_drive: expected %0h, got %0h", want.miso_drive, got.miso_drive);
			errors++;
		end
		if (got.frame_done !== want.frame_done) begin
			$error("frame_done: expected %0h, got %0h", want.frame_done, got.frame_done);
			errors++;
		end
		if (got.next_addr_valid !== want.next_addr_valid) begin
			$error("next_addr_valid: expected %0h, got %0h", want.next_addr_valid,
				got.next_addr_valid);
			errors++;
		end
		if (got.next_addr !== want.next_addr) begin
			$error("next_addr: expected %0h, got %0h", want.next_addr, got.next_addr);
			errors++;
		end
	endtask

	always @(posedge clk) begin : word_source
		sars_pkg::res_t want;
		if (cmd_valid && !cmd_stall) begin
			want = slave_response(cur.c);
			resp_due.push_back(cur.has_lit ? cur.lit : want);
			offering = 1'b0;
		end
		if (!(cmd_valid && cmd_stall)) begin
			if (word_backlog.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
				cur = word_backlog.pop_front();
				offering = 1'b1;
				cmd_valid <= 1'b1;
				cmd_word <= cur.c;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : word_sink
		if (res_valid && !res_stall) begin
			seen++;
			if (resp_due.size() == 0) begin
				$error("unexpected response word %h", res_word);
				errors++;
			end else begin
				compare_response(res_word, resp_due.pop_front());
			end
			if (seen == HOLD_AT)
				hold_left = HOLD_LEN;
		end
		if (hold_left != 0)
			hold_left--;
		res_stall <= (hold_left != 0) || (!calm && $urandom_range(99) < 22);
	end

	task automatic offer(input logic [1:0] func, input logic [7:0] data);
		stim_t s;
		s = '0;
		s.c.func = func;
		s.c.rx_byte = data;
		word_backlog.push_back(s);
		if (func != FUNC_NONE)
			words_queued++;
	endtask

	// Mostly well-formed frames with random content; the rest is noise and broken frames.
	task automatic queue_frame();
		int total;
		int idx;
		int len;
		logic [7:0] code;
		logic [7:0] dat;
		logic [4:0] tgt;
		total = reg_total();
		if ($urandom_range(99) < 8) begin
			offer(2'($urandom_range(3)), 8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(9) != 0)
			offer(sars_pkg::FUNC_START, 8'($urandom_range(255)));
		tgt = ($urandom_range(9) != 0) ? {2'b00, c_dev} : 5'($urandom_range(31));
		case ($urandom_range(9))
			0, 1, 2, 3: code = c_base;
			4, 5, 6, 7: code = c_base + 8'd1;
			default: code = 8'($urandom_range(255));
		endcase
		offer(sars_pkg::FUNC_BYTE, (code & sars_pkg::OPC_MASK) | {2'b00, tgt, 1'b0});
		if ($urandom_range(19) == 0)
			return;
		len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6);
		case ($urandom_range(9))
			0, 1, 2, 3: idx = $urandom_range(total + 2);
			4: begin
				case ($urandom_range(3))
					0: idx = int'(sars_pkg::SW_IDX_A);
					1: idx = int'(sars_pkg::SW_IDX_B);
					2: idx = int'(sars_pkg::SW_IDX_C);
					default: idx = int'(sars_pkg::SW_IDX_D);
				endcase
			end
			5: idx = 0;
			6: idx = int'(c_sel) + 1;
			7: idx = total - 1 - $urandom_range(3);
			8: idx = $urandom_range(255);
			default: begin
				idx = 0;
				len = total + $urandom_range(2);
			end
		endcase
		offer(sars_pkg::FUNC_BYTE, 8'(idx));
		repeat (len) begin
			case ($urandom_range(7))
				0: dat = c_en;
				1: dat = c_dis;
				default: dat = 8'($urandom_range(255));
			endcase
			offer(sars_pkg::FUNC_BYTE, dat);
		end
		if ($urandom_range(99) < 35)
			offer(sars_pkg::FUNC_SERVICE, 8'($urandom_range(255)));
	endtask

	task automatic wait_idle();
		while (word_backlog.size() != 0 || offering || resp_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			sars_pkg::REG_BASE_CODE: c_base = val[7:0];
			sars_pkg::REG_CFG_SELECT: c_sel = val[3:0];
			sars_pkg::REG_USER_COUNT: c_users = val[6:0];
			sars_pkg::REG_DEV_ADDR: c_dev = val[2:0];
			sars_pkg::REG_EN_CODE: c_en = val[7:0];
			sars_pkg::REG_DIS_CODE: c_dis = val[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic apb_read(input logic [2:0] idx, output logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		val = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : run
		logic [31:0] cfg_val [6];
		logic [31:0] rb;
		logic [31:0] want;
		logic [2:0] r;
		int phase_end;
		for (int i = 0; i < BANK_DEPTH; i++)
			m_bank[i] = 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 26; i++)
			word_backlog.push_back(DIR_TAB[i]);
		wait_idle();
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					cfg_val[sars_pkg::REG_BASE_CODE] = 32'h00;
					cfg_val[sars_pkg::REG_CFG_SELECT] = 32'd0;
					cfg_val[sars_pkg::REG_USER_COUNT] = 32'd0;
					cfg_val[sars_pkg::REG_DEV_ADDR] = 32'd0;
					cfg_val[sars_pkg::REG_EN_CODE] = 32'h01;
					cfg_val[sars_pkg::REG_DIS_CODE] = 32'h00;
				end
				1: begin
					cfg_val[sars_pkg::REG_BASE_CODE] = 32'hC0;
					cfg_val[sars_pkg::REG_CFG_SELECT] = 32'd15;
					cfg_val[sars_pkg::REG_USER_COUNT] = 32'd64;
					cfg_val[sars_pkg::REG_DEV_ADDR] = 32'd7;
					cfg_val[sars_pkg::REG_EN_CODE] = 32'hFF;
					cfg_val[sars_pkg::REG_DIS_CODE] = 32'h00;
				end
				2: begin
					cfg_val[sars_pkg::REG_BASE_CODE] = 32'h40;
					cfg_val[sars_pkg::REG_CFG_SELECT] = 32'd4;
					cfg_val[sars_pkg::REG_USER_COUNT] = 32'd127;
					cfg_val[sars_pkg::REG_DEV_ADDR] = 32'd5;
					cfg_val[sars_pkg::REG_EN_CODE] = 32'h00;
					cfg_val[sars_pkg::REG_DIS_CODE] = 32'hFF;
				end
				3: begin
					cfg_val[sars_pkg::REG_BASE_CODE] = 32'hFF;
					cfg_val[sars_pkg::REG_CFG_SELECT] = 32'd14;
					cfg_val[sars_pkg::REG_USER_COUNT] = 32'd3;
					cfg_val[sars_pkg::REG_DEV_ADDR] = 32'd2;
					cfg_val[sars_pkg::REG_EN_CODE] = 32'h5A;
					cfg_val[sars_pkg::REG_DIS_CODE] = 32'h5A;
				end
				4: begin
					cfg_val[sars_pkg::REG_BASE_CODE] = 32'h80;
					cfg_val[sars_pkg::REG_CFG_SELECT] = 32'd9;
					cfg_val[sars_pkg::REG_USER_COUNT] = 32'd20;
					cfg_val[sars_pkg::REG_DEV_ADDR] = 32'd1;
					cfg_val[sars_pkg::REG_EN_CODE] = 32'hA5;
					cfg_val[sars_pkg::REG_DIS_CODE] = 32'h3C;
				end
				default: begin
					cfg_val[sars_pkg::REG_BASE_CODE] = ($urandom_range(3) == 0) ? $urandom()
						: {24'd0, 2'($urandom_range(3)), 6'b000000};
					cfg_val[sars_pkg::REG_CFG_SELECT] = $urandom();
					cfg_val[sars_pkg::REG_USER_COUNT] = $urandom();
					cfg_val[sars_pkg::REG_DEV_ADDR] = $urandom();
					cfg_val[sars_pkg::REG_EN_CODE] = $urandom();
					cfg_val[sars_pkg::REG_DIS_CODE] = $urandom();
				end
			endcase
			for (int k = 0; k < 6; k++)
				apb_write(CFG_ORDER[k], cfg_val[CFG_ORDER[k]]);
			for (int k = 0; k < 6; k++) begin
				r = CFG_ORDER[k];
				apb_read(r, rb);
				case (r)
					sars_pkg::REG_BASE_CODE: want = {24'd0, c_base};
					sars_pkg::REG_CFG_SELECT: want = {28'd0, c_sel};
					sars_pkg::REG_USER_COUNT: want = {25'd0, c_users};
					sars_pkg::REG_DEV_ADDR: want = {29'd0, c_dev};
					sars_pkg::REG_EN_CODE: want = {24'd0, c_en};
					default: want = {24'd0, c_dis};
				endcase
				if (rb !== want) begin
					$error("prdata at %0h: expected %0h, got %0h", {r, 2'b00}, want, rb);
					errors++;
				end
			end
			phase_end = words_queued + PHASE_WORDS;
			while (words_queued < phase_end) begin
				while (word_backlog.size() > 16)
					@(posedge clk);
				queue_frame();
			end
			wait_idle();
		end
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("** spi_addressed_register_slave: PASSED **");
		else
			$display("** spi_addressed_register_slave: FAILED **");
		$finish;
	end
endmodule
